>>> hw/rtl/first_fit_swap_segment_allocator_macros.svh
// assertion macros for the swap segment allocator
// no dependencies; assertions vanish when NO_ASSERTIONS is defined
`ifndef FIRST_FIT_SWAP_SEGMENT_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_SWAP_SEGMENT_ALLOCATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FFSA_ASSERT_IMPL(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("assertion failed");
`define FFSA_ASSERT_NEXT(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define FFSA_ASSERT_IMPL(label, clk, rstn, a, c)
`define FFSA_ASSERT_NEXT(label, clk, rstn, a, c)
`endif
`endif

>>> hw/rtl/ffsa_pkg.sv
// shared types and codes for the swap segment allocator
// no dependencies
`timescale 1ns / 1ps
package ffsa_pkg;
    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_WRITE = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NOSPACE = 3'd1;
    localparam logic [2:0] ST_NOPID   = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_BEYOND  = 3'd4;

    localparam logic [0:0] REG_TOTAL_PAGES = 1'd0;
    localparam logic [0:0] REG_PAGE_SIZE   = 1'd1;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_FSCAN, S_FSHIFT, S_SSCAN, S_MSCAN,
        S_FREEUPD, S_SSHIFT, S_XLATE, S_MUL, S_OUT
    } state_t;

    typedef struct packed {
        logic load;      // capture input transaction
        logic fscan;     // advance free index
        logic fshift;    // move free[i+1] into free[i]
        logic fshrink;   // shrink found extent
        logic fdec;      // drop free count
        logic seg_app;   // append segment
        logic sscan;     // advance segment index
        logic mstart;    // restart free index for merge scan
        logic fmerge;    // grow found extent backward
        logic fapp;      // append new free extent
        logic sshift;    // move seg[k+1] into seg[k]
        logic sdec;      // drop segment count
        logic xlate;     // form absolute page
        logic mul;       // register byte address
        logic set_res;   // capture status
        logic [2:0] res_status;
        logic out_take;  // result accepted
    } ctl_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic seg_full;
        logic free_full;
        logic fend;       // free index reached count
        logic fhit_len;   // extent long enough
        logic fexact;     // extent used exactly
        logic fhit_start; // extent begins at segment end
        logic send;       // segment index reached count
        logic shit;       // owner matches pid
        logic fshift_end;
        logic sshift_end;
        logic beyond;
        logic out_valid;
    } sts_t;
endpackage

>>> hw/rtl/ffsa_ctrl.sv
// command sequencer for the swap segment allocator
// depends on ffsa_pkg
`timescale 1ns / 1ps
module ffsa_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic            m_ready,
    input  ffsa_pkg::sts_t  sts,
    output ffsa_pkg::ctl_t  ctl,
    output ffsa_pkg::state_t state
);
    import ffsa_pkg::*;
    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else          state_reg <= state_next;
    end
    assign state = state_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (s_valid && !sts.out_valid) state_next = S_CHECK;
            S_CHECK: begin
                if (sts.cmd == CMD_ALLOC) state_next = sts.seg_full ? S_OUT : S_FSCAN;
                else state_next = S_SSCAN;
            end
            S_FSCAN: begin
                if (sts.fend) state_next = S_OUT;
                else if (sts.fhit_len) state_next = sts.fexact ? S_FSHIFT : S_OUT;
            end
            S_FSHIFT: if (sts.fshift_end) state_next = S_OUT;
            S_SSCAN: begin
                if (sts.send) state_next = S_OUT;
                else if (sts.shit) state_next = (sts.cmd == CMD_FREE) ? S_MSCAN : S_XLATE;
            end
            S_MSCAN: if (sts.fend || sts.fhit_start) state_next = S_FREEUPD;
            S_FREEUPD: begin
                if (!sts.fhit_start && sts.free_full) state_next = S_OUT;
                else state_next = S_SSHIFT;
            end
            S_SSHIFT: if (sts.sshift_end) state_next = S_MUL;
            S_XLATE: state_next = S_MUL;
            S_MUL: state_next = S_OUT;
            S_OUT: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        ctl = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = !sts.out_valid;
                ctl.load = s_valid && !sts.out_valid;
            end
            S_CHECK: begin
                if (sts.cmd == CMD_ALLOC && sts.seg_full) begin
                    ctl.set_res = 1'b1; ctl.res_status = ST_FULL;
                end
            end
            S_FSCAN: begin
                if (sts.fend) begin
                    ctl.set_res = 1'b1; ctl.res_status = ST_NOSPACE;
                end else if (sts.fhit_len) begin
                    ctl.seg_app = 1'b1;
                    ctl.set_res = 1'b1; ctl.res_status = ST_OK;
                    if (!sts.fexact) ctl.fshrink = 1'b1;
                end else ctl.fscan = 1'b1;
            end
            S_FSHIFT: begin
                if (sts.fshift_end) ctl.fdec = 1'b1;
                else ctl.fshift = 1'b1;
            end
            S_SSCAN: begin
                if (sts.send) begin
                    ctl.set_res = 1'b1; ctl.res_status = ST_NOPID;
                end else if (sts.shit) ctl.mstart = 1'b1;
                else ctl.sscan = 1'b1;
            end
            S_MSCAN: if (!(sts.fend || sts.fhit_start)) ctl.fscan = 1'b1;
            S_FREEUPD: begin
                if (sts.fhit_start) ctl.fmerge = 1'b1;
                else if (sts.free_full) begin
                    ctl.set_res = 1'b1; ctl.res_status = ST_FULL;
                end else ctl.fapp = 1'b1;
            end
            S_SSHIFT: begin
                if (sts.sshift_end) begin
                    ctl.sdec = 1'b1;
                    ctl.set_res = 1'b1; ctl.res_status = ST_OK;
                end else ctl.sshift = 1'b1;
            end
            S_XLATE: begin
                ctl.xlate = 1'b1;
                ctl.set_res = 1'b1;
                ctl.res_status = sts.beyond ? ST_BEYOND : ST_OK;
            end
            S_MUL: ctl.mul = 1'b1;
            S_OUT: ctl.mul = 1'b1;
            default: ;
        endcase
        ctl.out_take = m_ready;
    end
endmodule

>>> hw/rtl/ffsa_datapath.sv
// tables, indices and result register for the swap segment allocator
// depends on ffsa_pkg
`timescale 1ns / 1ps
module ffsa_datapath #(
    parameter int FREE_SLOTS    = 16,
    parameter int SEGMENT_SLOTS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_init,
    input  logic [15:0]       init_pages,
    input  logic [15:0]       total_pages,
    input  logic [16:0]       page_size,
    input  logic [1:0]        s_cmd,
    input  logic [15:0]       s_pid,
    input  logic [15:0]       s_page_count,
    input  logic [15:0]       s_page_offset,
    input  ffsa_pkg::ctl_t    ctl,
    input  ffsa_pkg::state_t  state,
    output ffsa_pkg::sts_t    sts,
    output logic              m_valid,
    output logic              m_ok,
    output logic [2:0]        m_status,
    output logic [15:0]       m_start_page,
    output logic [31:0]       m_byte_address
);
    import ffsa_pkg::*;
    localparam int FW = $clog2(FREE_SLOTS);
    localparam int SW = $clog2(SEGMENT_SLOTS);

    logic [15:0] free_start_reg [FREE_SLOTS];
    logic [15:0] free_len_reg   [FREE_SLOTS];
    logic [15:0] seg_owner_reg  [SEGMENT_SLOTS];
    logic [15:0] seg_start_reg  [SEGMENT_SLOTS];
    logic [15:0] seg_len_reg    [SEGMENT_SLOTS];
    logic [FW:0] free_used_reg;
    logic [SW:0] seg_used_reg;
    logic [FW:0] fi_reg;
    logic [SW:0] si_reg;
    logic [1:0]  cmd_reg;
    logic [15:0] pid_reg, cnt_reg, off_reg;
    logic [15:0] page_reg;
    logic [2:0]  status_reg;
    logic        valid_reg;
    logic [31:0] addr_reg;

    logic [FW-1:0] fi, fi1;
    logic [SW-1:0] si, si1;
    logic [15:0]   fs, fl, so, ss, sl, fs1, fl1;
    logic [16:0]   xpage, send_page;

    assign fi  = fi_reg[FW-1:0];
    assign si  = si_reg[SW-1:0];
    assign fi1 = (fi == FW'(FREE_SLOTS - 1)) ? fi : fi + 1'b1;
    assign si1 = (si == SW'(SEGMENT_SLOTS - 1)) ? si : si + 1'b1;
    assign fs  = free_start_reg[fi];
    assign fl  = free_len_reg[fi];
    assign fs1 = free_start_reg[fi1];
    assign fl1 = free_len_reg[fi1];
    assign so  = seg_owner_reg[si];
    assign ss  = seg_start_reg[si];
    assign sl  = seg_len_reg[si];
    assign send_page = {1'b0, ss} + {1'b0, sl};
    assign xpage = {1'b0, ss} + {1'b0, off_reg};

    always_comb begin
        sts.cmd        = cmd_reg;
        sts.seg_full   = seg_used_reg >= (SW+1)'(SEGMENT_SLOTS);
        sts.free_full  = free_used_reg >= (FW+1)'(FREE_SLOTS);
        sts.fend       = fi_reg >= free_used_reg;
        sts.fhit_len   = fl >= cnt_reg;
        sts.fexact     = fl == cnt_reg;
        sts.fhit_start = !sts.fend && ({1'b0, fs} == send_page);
        sts.send       = si_reg >= seg_used_reg;
        sts.shit       = so == pid_reg;
        sts.fshift_end = (fi_reg + 1'b1) >= free_used_reg;
        sts.sshift_end = (si_reg + 1'b1) >= seg_used_reg;
        sts.beyond     = xpage >= {1'b0, total_pages};
        sts.out_valid  = valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_init) begin
            free_used_reg <= (init_pages != 16'd0 || !aresetn) ? (FW+1)'(1) : '0;
            seg_used_reg  <= '0;
            valid_reg     <= 1'b0;
            fi_reg        <= '0;
            si_reg        <= '0;
        end else begin
            if (ctl.load) begin
                fi_reg <= '0;
                si_reg <= '0;
            end
            if (ctl.fscan || ctl.fshift) fi_reg <= fi_reg + 1'b1;
            if (ctl.mstart) fi_reg <= '0;
            if (ctl.sscan || ctl.sshift) si_reg <= si_reg + 1'b1;
            if (ctl.fdec) free_used_reg <= free_used_reg - 1'b1;
            if (ctl.fapp) free_used_reg <= free_used_reg + 1'b1;
            if (ctl.seg_app) seg_used_reg <= seg_used_reg + 1'b1;
            if (ctl.sdec) seg_used_reg <= seg_used_reg - 1'b1;
            if (state == S_OUT) valid_reg <= 1'b1;
            else if (valid_reg && ctl.out_take) valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_init) begin
            free_start_reg[0] <= '0;
            free_len_reg[0]   <= aresetn ? init_pages : 16'd256;
        end else begin
            if (ctl.fshrink) begin
                free_start_reg[fi] <= fs + cnt_reg;
                free_len_reg[fi]   <= fl - cnt_reg;
            end
            if (ctl.fshift) begin
                free_start_reg[fi] <= fs1;
                free_len_reg[fi]   <= fl1;
            end
            if (ctl.fmerge) begin
                free_start_reg[fi] <= seg_start_reg[si];
                free_len_reg[fi]   <= fl + seg_len_reg[si];
            end
            if (ctl.fapp) begin
                free_start_reg[free_used_reg[FW-1:0]] <= ss;
                free_len_reg[free_used_reg[FW-1:0]]   <= sl;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            cmd_reg <= s_cmd;
            pid_reg <= s_pid;
            cnt_reg <= s_page_count;
            off_reg <= s_page_offset;
        end
        if (ctl.seg_app) begin
            seg_owner_reg[seg_used_reg[SW-1:0]] <= pid_reg;
            seg_start_reg[seg_used_reg[SW-1:0]] <= fs;
            seg_len_reg[seg_used_reg[SW-1:0]]   <= cnt_reg;
            page_reg <= fs;
        end
        if (ctl.mstart) page_reg <= ss;
        if (ctl.sshift) begin
            seg_owner_reg[si] <= seg_owner_reg[si1];
            seg_start_reg[si] <= seg_start_reg[si1];
            seg_len_reg[si]   <= seg_len_reg[si1];
        end
        if (ctl.xlate) page_reg <= xpage[15:0];
        if (ctl.set_res) status_reg <= ctl.res_status;
        if (ctl.mul) addr_reg <= 32'({16'd0, page_reg} * {15'd0, page_size});
    end

    assign m_valid        = valid_reg;
    assign m_ok           = status_reg == ST_OK;
    assign m_status       = status_reg;
    assign m_start_page   = m_ok ? page_reg : 16'd0;
    assign m_byte_address = m_ok ? addr_reg : 32'd0;
endmodule

>>> hw/rtl/first_fit_swap_segment_allocator.sv
// top level: apb registers, sequencer and table datapath
// depends on ffsa_pkg, ffsa_ctrl, ffsa_datapath and the macros header
// time from accept to result depends on the serial scans and shifts over
// the two tables, one entry a cycle
// one command in flight at a time; the next is taken once the result is handed over
// synchronous active-low reset: 256 pages of 256 bytes, one free extent, no segments
`timescale 1ns / 1ps
`include "first_fit_swap_segment_allocator_macros.svh"
module first_fit_swap_segment_allocator #(
    parameter int FREE_SLOTS    = 16,
    parameter int SEGMENT_SLOTS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [15:0] s_pid,
    input  logic [15:0] s_page_count,
    input  logic [15:0] s_page_offset,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_ok,
    output logic [2:0]  m_status,
    output logic [15:0] m_start_page,
    output logic [31:0] m_byte_address
);
    import ffsa_pkg::*;
    logic [15:0] total_pages_reg;
    logic [16:0] page_size_reg;
    logic        wr, cfg_init;
    ctl_t        ctl;
    sts_t        sts;
    state_t      state;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;
    assign cfg_init = wr && paddr[1:0] == 2'd0 && paddr[2] == REG_TOTAL_PAGES;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_pages_reg <= 16'd256;
            page_size_reg   <= 17'd256;
        end else if (wr && paddr[1:0] == 2'd0) begin
            if (paddr[2] == REG_TOTAL_PAGES) total_pages_reg <= pwdata[15:0];
            else page_size_reg <= pwdata[16:0];
        end
    end

    always_comb begin
        if (paddr[2] == REG_PAGE_SIZE) prdata = {15'd0, page_size_reg};
        else prdata = {16'd0, total_pages_reg};
    end

    ffsa_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .m_ready, .sts, .ctl, .state
    );

    // tables are rebuilt from the value being written
    ffsa_datapath #(.FREE_SLOTS(FREE_SLOTS), .SEGMENT_SLOTS(SEGMENT_SLOTS)) u_dp (
        .aclk, .aresetn, .cfg_init,
        .init_pages(pwdata[15:0]), .total_pages(total_pages_reg),
        .page_size(page_size_reg),
        .s_cmd, .s_pid, .s_page_count, .s_page_offset,
        .ctl, .state, .sts,
        .m_valid, .m_ok, .m_status, .m_start_page, .m_byte_address
    );

    `FFSA_ASSERT_IMPL(a_no_accept_busy, aclk, aresetn, m_valid, !s_ready)
    `FFSA_ASSERT_IMPL(a_ok_status, aclk, aresetn, m_valid && m_ok, m_status == ST_OK)
    `FFSA_ASSERT_NEXT(a_accept_starts, aclk, aresetn, s_valid && s_ready, state == S_CHECK)
endmodule

>>> tb/first_fit_swap_segment_allocator_tb.sv
// testbench for the first-fit swap segment allocator: own table predictor
// depends on ffsa_pkg and the first_fit_swap_segment_allocator rtl
`timescale 1ns / 1ps
module first_fit_swap_segment_allocator_tb;
    import ffsa_pkg::*;

    typedef struct packed {
        logic        ok;
        logic [2:0]  status;
        logic [15:0] start_page;
        logic [31:0] byte_address;
    } answer_t;

    class alloc_scoreboard;
        logic [15:0] n_pages;
        logic [16:0] pg_bytes;
        logic [15:0] ext_start[16];
        logic [15:0] ext_len[16];
        int          ext_cnt;
        logic [15:0] seg_pid[16];
        logic [15:0] seg_base[16];
        logic [15:0] seg_len[16];
        int          seg_cnt;
        answer_t     pending[$];
        int          errors;
        int          checked;
        int          status_seen[5];

        function void clear_tables();
            seg_cnt = 0;
            ext_cnt = 0;
            if (n_pages != 0) begin
                ext_start[0] = 0;
                ext_len[0] = n_pages;
                ext_cnt = 1;
            end
        endfunction

        function void set_total(logic [15:0] v);
            n_pages = v;
            clear_tables();
        endfunction

        function answer_t reply(logic [2:0] st, logic [15:0] pg);
            answer_t a;
            logic [63:0] prod;
            prod = 64'(pg) * 64'(pg_bytes);
            a.ok = (st == ST_OK);
            a.status = st;
            a.start_page = a.ok ? pg : 16'd0;
            a.byte_address = a.ok ? prod[31:0] : 32'd0;
            return a;
        endfunction

        function answer_t predict(logic [1:0] c, logic [15:0] p, logic [15:0] n,
                                  logic [15:0] off);
            int i;
            int k;
            logic [15:0] base;
            logic [15:0] len;
            logic [16:0] pg;
            if (c == CMD_ALLOC) begin
                if (seg_cnt >= 16) return reply(ST_FULL, 0);
                for (i = 0; i < ext_cnt; i++)
                    if (ext_len[i] >= n) break;
                if (i >= ext_cnt) return reply(ST_NOSPACE, 0);
                base = ext_start[i];
                if (ext_len[i] > n) begin
                    ext_start[i] = base + n;
                    ext_len[i] = ext_len[i] - n;
                end else begin
                    for (; i + 1 < ext_cnt; i++) begin
                        ext_start[i] = ext_start[i+1];
                        ext_len[i] = ext_len[i+1];
                    end
                    ext_cnt--;
                end
                seg_pid[seg_cnt] = p;
                seg_base[seg_cnt] = base;
                seg_len[seg_cnt] = n;
                seg_cnt++;
                return reply(ST_OK, base);
            end
            for (k = 0; k < seg_cnt; k++)
                if (seg_pid[k] == p) break;
            if (k >= seg_cnt) return reply(ST_NOPID, 0);
            base = seg_base[k];
            len = seg_len[k];
            if (c == CMD_FREE) begin
                for (i = 0; i < ext_cnt; i++)
                    if (17'(ext_start[i]) == 17'(base) + 17'(len)) break;
                if (i < ext_cnt) begin
                    ext_start[i] = base;
                    ext_len[i] = ext_len[i] + len;
                end else begin
                    if (ext_cnt >= 16) return reply(ST_FULL, 0);
                    ext_start[ext_cnt] = base;
                    ext_len[ext_cnt] = len;
                    ext_cnt++;
                end
                for (; k + 1 < seg_cnt; k++) begin
                    seg_pid[k] = seg_pid[k+1];
                    seg_base[k] = seg_base[k+1];
                    seg_len[k] = seg_len[k+1];
                end
                seg_cnt--;
                return reply(ST_OK, base);
            end
            pg = 17'(base) + 17'(off);
            if (pg >= 17'(n_pages)) return reply(ST_BEYOND, 0);
            return reply(ST_OK, pg[15:0]);
        endfunction

        function void note_command(logic [1:0] c, logic [15:0] p, logic [15:0] n,
                                   logic [15:0] off);
            pending.push_back(predict(c, p, n, off));
        endfunction

        function void check_result(answer_t got);
            answer_t want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (want.status <= ST_BEYOND) status_seen[want.status]++;
            if (got.ok !== want.ok) begin
                $display("%0t: ok expected %0d actual %0d", $time, want.ok, got.ok);
                errors++;
            end
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d actual %0d", $time, want.status,
                         got.status);
                errors++;
            end
            if (got.start_page !== want.start_page) begin
                $display("%0t: start_page expected %0d actual %0d", $time,
                         want.start_page, got.start_page);
                errors++;
            end
            if (got.byte_address !== want.byte_address) begin
                $display("%0t: byte_address expected %h actual %h", $time,
                         want.byte_address, got.byte_address);
                errors++;
            end
        endfunction
    endclass

    logic aclk, aresetn;
    logic psel, penable, pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata, prdata;
    logic pready;
    logic s_valid, s_ready;
    logic [1:0] s_cmd;
    logic [15:0] s_pid, s_page_count, s_page_offset;
    logic m_valid, m_ready, m_ok;
    logic [2:0] m_status;
    logic [15:0] m_start_page;
    logic [31:0] m_byte_address;

    alloc_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;

    first_fit_swap_segment_allocator dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd), .s_pid(s_pid),
        .s_page_count(s_page_count), .s_page_offset(s_page_offset),
        .m_valid(m_valid), .m_ready(m_ready), .m_ok(m_ok), .m_status(m_status),
        .m_start_page(m_start_page), .m_byte_address(m_byte_address)
    );

    initial begin
        aclk = 0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("first_fit_swap_segment_allocator test failed");
        $finish;
    end

    // receiver: random stall, check on each accepted transaction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result({m_ok, m_status, m_start_page, m_byte_address});
        if (aresetn) m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic reg_write(logic [0:0] idx, logic [31:0] v);
        @(posedge aclk);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= {idx, 2'b00}; pwdata <= v;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        if (idx == REG_TOTAL_PAGES) sb.set_total(v[15:0]);
        else sb.pg_bytes = v[16:0];
    endtask

    task automatic wait_drained();
        s_valid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    // valid drops only on idle cycles, so back-to-back transactions keep it high
    task automatic send_cmd(logic [1:0] c, logic [15:0] p, logic [15:0] n,
                            logic [15:0] off);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1; s_cmd <= c; s_pid <= p; s_page_count <= n; s_page_offset <= off;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_command(c, p, n, off);
    endtask

    // mostly alloc/free/translate on a small pid pool, some wild values
    task automatic random_cmd();
        logic [1:0] c;
        logic [15:0] p, n, off;
        c = 2'($urandom_range(3));
        p = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(7));
        case ($urandom_range(4))
            0: n = 16'($urandom);
            1: n = 0;
            default: n = 16'($urandom_range(40));
        endcase
        off = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(30));
        send_cmd(c, p, n, off);
    endtask

    initial begin
        int j;
        sb = new();
        sb.pg_bytes = 256;
        sb.set_total(256);
        send_idle_pct = 6; recv_idle_pct = 80;
        aresetn = 0; psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        s_valid = 0; s_cmd = CMD_ALLOC; s_pid = 0; s_page_count = 0; s_page_offset = 0;
        m_ready = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1;

        // directed: extremes, every command, zero sizes, duplicates, misses
        send_cmd(CMD_READ, 16'd5, 0, 0);
        send_cmd(CMD_ALLOC, 16'd1, 16'd0, 0);
        send_cmd(CMD_ALLOC, 16'd1, 16'd10, 0);
        send_cmd(CMD_ALLOC, 16'hFFFF, 16'd100, 0);
        send_cmd(CMD_ALLOC, 16'd2, 16'hFFFF, 0);
        send_cmd(CMD_READ, 16'hFFFF, 0, 16'd99);
        send_cmd(CMD_WRITE, 16'hFFFF, 0, 16'd200);
        send_cmd(CMD_WRITE, 16'hFFFF, 0, 16'hFFFF);
        send_cmd(CMD_FREE, 16'd1, 0, 0);
        send_cmd(CMD_FREE, 16'd1, 0, 0);
        send_cmd(CMD_FREE, 16'hFFFF, 0, 0);
        send_cmd(CMD_ALLOC, 16'd3, 16'd256, 0);
        send_cmd(CMD_FREE, 16'd7, 0, 0);
        wait_drained();

        reg_write(REG_PAGE_SIZE, 32'h10000);
        reg_write(REG_TOTAL_PAGES, 32'hFFFF);
        send_cmd(CMD_ALLOC, 16'd4, 16'hFFFF, 0);
        send_cmd(CMD_WRITE, 16'd4, 0, 16'hFFFE);
        send_cmd(CMD_ALLOC, 16'd4, 16'd0, 0);
        send_cmd(CMD_FREE, 16'd4, 0, 0);
        wait_drained();
        reg_write(REG_PAGE_SIZE, 32'd0);
        reg_write(REG_TOTAL_PAGES, 32'd0);
        send_cmd(CMD_ALLOC, 16'd1, 16'd0, 0);
        wait_drained();

        // fill the segment table, then fragment the free table
        reg_write(REG_PAGE_SIZE, 32'd1);
        reg_write(REG_TOTAL_PAGES, 32'd40);
        for (j = 0; j < 17; j++) send_cmd(CMD_ALLOC, 16'(j), 16'd2, 0);
        for (j = 0; j < 16; j += 2) send_cmd(CMD_FREE, 16'(j), 0, 0);
        wait_drained();

        for (j = 0; j < 700; j++) begin
            if (j == 240) begin send_idle_pct = 80; recv_idle_pct = 6; end
            if (j == 470) begin send_idle_pct = 0; recv_idle_pct = 0; end
            if (j % 110 == 60) begin
                wait_drained();
                case ($urandom_range(3))
                    0: reg_write(REG_TOTAL_PAGES, 32'd1);
                    1: reg_write(REG_TOTAL_PAGES, 32'($urandom_range(30, 120)));
                    2: reg_write(REG_TOTAL_PAGES, 32'($urandom));
                    default: reg_write(REG_TOTAL_PAGES, 32'd256);
                endcase
                reg_write(REG_PAGE_SIZE, 32'($urandom_range(1, 17'h1FFFF)));
            end
            random_cmd();
        end
        wait_drained();

        $display("covered %0d commands: ok %0d, no space %0d, unknown pid %0d,",
                 sb.checked, sb.status_seen[0], sb.status_seen[1], sb.status_seen[2]);
        $display("table full %0d, beyond partition %0d, across several configurations",
                 sb.status_seen[3], sb.status_seen[4]);
        if (sb.errors == 0)
            $display("first_fit_swap_segment_allocator test passed");
        else
            $display("first_fit_swap_segment_allocator test failed");
        $finish;
    end
endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/ffsa_pkg.sv
hw/rtl/ffsa_ctrl.sv
hw/rtl/ffsa_datapath.sv
hw/rtl/first_fit_swap_segment_allocator.sv
tb/first_fit_swap_segment_allocator_tb.sv
